// File: src/sib_pkg.sv
// Shared types and constants for the interframe blend block.
// Depends on nothing; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps

package sib_pkg;

   localparam int PIXEL_WIDTH = 32;
   localparam int FRAME_PIXELS_DEFAULT = 65536;
   localparam int NUM_STORES = 3;
   localparam logic [PIXEL_WIDTH-1:0] BLEND_MASK_RESET = 32'h00fe_fefe;

   // Physical frame store numbers.
   localparam int STORE_A = 0;
   localparam int STORE_B = 1;
   localparam int STORE_C = 2;

   // Role rotation of the three frame stores.
   typedef enum logic [1:0] {
      PHASE_0 = 2'd0,
      PHASE_1 = 2'd1,
      PHASE_2 = 2'd2
   } sib_phase_type;

   // Request as it waits for the frame store read data.
   typedef struct packed {
      logic [PIXEL_WIDTH-1:0] pixel;
      logic                   frame_end;
      sib_phase_type          phase;
   } sib_s1_type;

   // Comparison results and halved terms ahead of the final add.
   typedef struct packed {
      logic [PIXEL_WIDTH-1:0] pixel;
      logic                   frame_end;
      logic                   ne_one_two;
      logic                   ne_three_cur;
      logic                   eq_cur_two;
      logic                   eq_one_three;
      logic [PIXEL_WIDTH-1:0] half_cur;
      logic [PIXEL_WIDTH-1:0] half_one;
   } sib_s2_type;

endpackage

// File: src/sib_if.sv
// Valid/ready stream interfaces for the request and response channels.
// Depends on sib_pkg for the pixel width.
`timescale 1ns / 1ps

interface sib_req_if;
   logic                            valid;
   logic                            ready;
   logic [sib_pkg::PIXEL_WIDTH-1:0] pixel_in;
   logic                            frame_end;

   modport source (output valid, output pixel_in, output frame_end, input ready);
   modport sink (input valid, input pixel_in, input frame_end, output ready);
endinterface

interface sib_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [sib_pkg::PIXEL_WIDTH-1:0] pixel_out;
   logic                            frame_end_out;

   modport source (output valid, output pixel_out, output frame_end_out, input ready);
   modport sink (input valid, input pixel_out, input frame_end_out, output ready);
endinterface

// File: src/smart_interframe_blend_core.sv
// Top level of the flicker-reducing interframe blender: frame stores, addressing and roles.
// Depends on sib_pkg, sib_if, sib_ram and sib_blend_pipe.
`timescale 1ns / 1ps

//  Channel   Direction  Handshake          Contents
//  req_chan  in         valid/ready        pixel_in[31:0], frame_end
//  rsp_chan  out        valid/ready        pixel_out[31:0], frame_end_out
//  csr_*     in         csr_wr_en, strobe  blend_mask write data csr_wr_data[31:0]
//
//  One request is accepted per clock unless the read stage stalls or clearing runs;
//  the response passes stages for the frame store read, flicker compare and blend add.
//  All three frame store RAMs are read, and the one holding the oldest frame is written,
//  at the same address in the accept cycle, which sets the one-request-per-clock rate.
//  After reset a clearing pass writes zero to every address of all the stores;
//  no request is accepted during it, while blend_mask writes are taken at any time.
//  Each stage advances when the next one is empty or moving, so a stalled response
//  still lets requests fill the bubbles ahead of it.

module smart_interframe_blend_core #(
   parameter int FRAME_PIXELS = sib_pkg::FRAME_PIXELS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   sib_req_if.sink                         req_chan,
   sib_rsp_if.source                       rsp_chan,
   input  logic                            csr_wr_en,
   input  logic [sib_pkg::PIXEL_WIDTH-1:0] csr_wr_data
);

   localparam int ADDR_WIDTH = $clog2(FRAME_PIXELS);
   localparam logic [ADDR_WIDTH-1:0] LAST_ADDR = ADDR_WIDTH'(FRAME_PIXELS - 1);

   logic [sib_pkg::PIXEL_WIDTH-1:0] blend_mask_ff;
   logic [sib_pkg::PIXEL_WIDTH-1:0] blend_mask_in;
   logic [ADDR_WIDTH-1:0]           addr_ff;
   logic [ADDR_WIDTH-1:0]           addr_in;
   sib_pkg::sib_phase_type          phase_ff;
   sib_pkg::sib_phase_type          phase_in;
   sib_pkg::sib_phase_type          phase_next;
   logic                            clear_busy_ff;
   logic                            clear_busy_in;
   logic [ADDR_WIDTH-1:0]           clear_addr_ff;
   logic [ADDR_WIDTH-1:0]           clear_addr_in;
   logic                            s1_valid_ff;
   logic                            s1_valid_in;
   sib_pkg::sib_s1_type             s1_ff;
   logic                            s1_en;
   logic                            s2_ready;
   logic                            accept;
   logic [sib_pkg::NUM_STORES-1:0]  wr_sel;
   logic [sib_pkg::NUM_STORES-1:0]  store_wr_en;
   logic [ADDR_WIDTH-1:0]           store_wr_addr;
   logic [sib_pkg::PIXEL_WIDTH-1:0] store_wr_data;
   logic [sib_pkg::PIXEL_WIDTH-1:0] store_rd_data [sib_pkg::NUM_STORES];

   // The read stage moves whenever it is empty or the compare stage takes its request.
   assign s1_en          = !s1_valid_ff || s2_ready;
   assign req_chan.ready = s1_en && !clear_busy_ff;
   assign accept         = req_chan.valid && req_chan.ready;

   assign blend_mask_in = csr_wr_en ? csr_wr_data : blend_mask_ff;

   // Next pixel address: back to zero at frame end and when the store size is passed.
   always_comb begin
      addr_in = addr_ff;
      if (accept) begin
         if (req_chan.frame_end || (addr_ff == LAST_ADDR)) begin
            addr_in = '0;
         end else begin
            addr_in = addr_ff + 1'b1;
         end
      end
   end

   always_comb begin
      unique case (phase_ff)
         sib_pkg::PHASE_0: phase_next = sib_pkg::PHASE_1;
         sib_pkg::PHASE_1: phase_next = sib_pkg::PHASE_2;
         sib_pkg::PHASE_2: phase_next = sib_pkg::PHASE_0;
         default:          phase_next = sib_pkg::PHASE_0;
      endcase
   end

   assign phase_in = (accept && req_chan.frame_end) ? phase_next : phase_ff;

   // The store that holds the frame three back takes the current pixel.
   always_comb begin
      wr_sel = '0;
      unique case (phase_ff)
         sib_pkg::PHASE_0: wr_sel[sib_pkg::STORE_C] = 1'b1;
         sib_pkg::PHASE_1: wr_sel[sib_pkg::STORE_B] = 1'b1;
         sib_pkg::PHASE_2: wr_sel[sib_pkg::STORE_A] = 1'b1;
         default:          wr_sel = '0;
      endcase
   end

   // Clearing pass: one address per cycle in all three stores at once.
   assign clear_addr_in = clear_busy_ff ? clear_addr_ff + 1'b1 : clear_addr_ff;
   assign clear_busy_in = clear_busy_ff && (clear_addr_ff != LAST_ADDR);

   assign store_wr_addr = clear_busy_ff ? clear_addr_ff : addr_ff;
   assign store_wr_data = clear_busy_ff ? '0 : req_chan.pixel_in;

   always_comb begin
      for (int i = 0; i < sib_pkg::NUM_STORES; i++) begin
         store_wr_en[i] = clear_busy_ff || (accept && wr_sel[i]);
      end
   end

   // The read returns the old contents even as the same address is written, which
   // matches read-then-write order. Later requests see the new pixel in the array.
   for (genvar g = 0; g < sib_pkg::NUM_STORES; g++) begin : g_store
      sib_ram #(
         .WIDTH (sib_pkg::PIXEL_WIDTH),
         .DEPTH (FRAME_PIXELS)
      ) u_store (
         .clock   (clock),
         .wr_en   (store_wr_en[g]),
         .wr_addr (store_wr_addr),
         .wr_data (store_wr_data),
         .rd_en   (s1_en),
         .rd_addr (addr_ff),
         .rd_data (store_rd_data[g])
      );
   end

   assign s1_valid_in = s1_en ? accept : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         blend_mask_ff <= sib_pkg::BLEND_MASK_RESET;
         addr_ff       <= '0;
         phase_ff      <= sib_pkg::PHASE_0;
         clear_busy_ff <= 1'b1;
         clear_addr_ff <= '0;
         s1_valid_ff   <= 1'b0;
      end else begin
         blend_mask_ff <= blend_mask_in;
         addr_ff       <= addr_in;
         phase_ff      <= phase_in;
         clear_busy_ff <= clear_busy_in;
         clear_addr_ff <= clear_addr_in;
         s1_valid_ff   <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff.pixel     <= req_chan.pixel_in;
         s1_ff.frame_end <= req_chan.frame_end;
         s1_ff.phase     <= phase_ff;
      end
   end

   sib_blend_pipe u_blend (
      .clock      (clock),
      .reset      (reset),
      .s1_valid   (s1_valid_ff),
      .s1_data    (s1_ff),
      .store_data (store_rd_data),
      .blend_mask (blend_mask_ff),
      .s2_ready   (s2_ready),
      .rsp_chan   (rsp_chan)
   );

   // A frame end always restarts addressing at the first pixel.
   a_frame_end_restart: assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.frame_end |=> addr_ff == '0)
      else $error("address not restarted after frame end");

   // The clearing pass ends only after the last address has been written.
   a_clear_complete: assert property (@(posedge clock) disable iff (reset)
      $fell(clear_busy_ff) |-> $past(clear_addr_ff) == LAST_ADDR)
      else $error("clearing pass ended early");

   // Outside the clearing pass at most one store is written per cycle.
   a_single_store_write: assert property (@(posedge clock) disable iff (reset)
      !clear_busy_ff |-> $onehot0(store_wr_en))
      else $error("more than one frame store written");

   // An accepted request always occupies the read stage in the next cycle.
   a_accept_fills_s1: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted request lost before the read stage");

endmodule

// File: src/sib_ram.sv
// Generic single-write, single-read RAM with registered read data.
// A read and a write to the same address in one cycle return the old contents.
`timescale 1ns / 1ps

module sib_ram #(
   parameter int WIDTH = sib_pkg::PIXEL_WIDTH,
   parameter int DEPTH = sib_pkg::FRAME_PIXELS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/sib_blend_pipe.sv
// Compare and blend stages: flicker test on the frame history and the masked average.
// Depends on sib_pkg and sib_if; fed by the frame store read stage of the top level.
`timescale 1ns / 1ps

module sib_blend_pipe (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            s1_valid,
   input  sib_pkg::sib_s1_type             s1_data,
   input  logic [sib_pkg::PIXEL_WIDTH-1:0] store_data [sib_pkg::NUM_STORES],
   input  logic [sib_pkg::PIXEL_WIDTH-1:0] blend_mask,
   output logic                            s2_ready,
   sib_rsp_if.source                       rsp_chan
);

   logic [sib_pkg::PIXEL_WIDTH-1:0] one_ago;
   logic [sib_pkg::PIXEL_WIDTH-1:0] two_ago;
   logic [sib_pkg::PIXEL_WIDTH-1:0] three_ago;
   logic                            s2_en;
   logic                            s3_en;
   logic                            s2_valid_ff;
   logic                            s2_valid_in;
   sib_pkg::sib_s2_type             s2_ff;
   sib_pkg::sib_s2_type             s2_in;
   logic                            s3_valid_ff;
   logic                            s3_valid_in;
   logic [sib_pkg::PIXEL_WIDTH-1:0] s3_pixel_ff;
   logic [sib_pkg::PIXEL_WIDTH-1:0] s3_pixel_in;
   logic                            s3_frame_end_ff;
   logic                            flicker;

   assign s3_en    = !s3_valid_ff || rsp_chan.ready;
   assign s2_en    = !s2_valid_ff || s3_en;
   assign s2_ready = s2_en;

   // Map the physical stores onto their roles for the request's phase.
   always_comb begin
      unique case (s1_data.phase)
         sib_pkg::PHASE_0: begin
            one_ago   = store_data[sib_pkg::STORE_A];
            two_ago   = store_data[sib_pkg::STORE_B];
            three_ago = store_data[sib_pkg::STORE_C];
         end
         sib_pkg::PHASE_1: begin
            one_ago   = store_data[sib_pkg::STORE_C];
            two_ago   = store_data[sib_pkg::STORE_A];
            three_ago = store_data[sib_pkg::STORE_B];
         end
         sib_pkg::PHASE_2: begin
            one_ago   = store_data[sib_pkg::STORE_B];
            two_ago   = store_data[sib_pkg::STORE_C];
            three_ago = store_data[sib_pkg::STORE_A];
         end
         default: begin
            one_ago   = store_data[sib_pkg::STORE_A];
            two_ago   = store_data[sib_pkg::STORE_B];
            three_ago = store_data[sib_pkg::STORE_C];
         end
      endcase
   end

   always_comb begin
      s2_in.pixel        = s1_data.pixel;
      s2_in.frame_end    = s1_data.frame_end;
      s2_in.ne_one_two   = (one_ago != two_ago);
      s2_in.ne_three_cur = (three_ago != s1_data.pixel);
      s2_in.eq_cur_two   = (s1_data.pixel == two_ago);
      s2_in.eq_one_three = (one_ago == three_ago);
      s2_in.half_cur     = (s1_data.pixel & blend_mask) >> 1;
      s2_in.half_one     = (one_ago & blend_mask) >> 1;
   end

   assign s2_valid_in = s2_en ? s1_valid : s2_valid_ff;

   assign flicker = s2_ff.ne_one_two && s2_ff.ne_three_cur &&
                    (s2_ff.eq_cur_two || s2_ff.eq_one_three);

   // Both halves stay below 2^31, so the sum cannot carry out.
   assign s3_pixel_in = flicker ? (s2_ff.half_cur + s2_ff.half_one) : s2_ff.pixel;
   assign s3_valid_in = s3_en ? s2_valid_ff : s3_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_en) begin
         s2_ff <= s2_in;
      end
      if (s3_en) begin
         s3_pixel_ff     <= s3_pixel_in;
         s3_frame_end_ff <= s2_ff.frame_end;
      end
   end

   assign rsp_chan.valid         = s3_valid_ff;
   assign rsp_chan.pixel_out     = s3_pixel_ff;
   assign rsp_chan.frame_end_out = s3_frame_end_ff;

endmodule
